[hw/rtl/cce_pkg.sv]
// Cluster chain table engine: shared types, command codes and status codes.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package cce_pkg;

    // Entry value that ends a chain; zero marks a free entry
    localparam logic [15:0] END_MARK = 16'hFFFF;

    // Data start after reset
    localparam logic [7:0] DS_RESET = 8'd8;

    // Request codes
    localparam logic [2:0] REQ_FORMAT = 3'd0;
    localparam logic [2:0] REQ_ALLOC  = 3'd1;
    localparam logic [2:0] REQ_EXTEND = 3'd2;
    localparam logic [2:0] REQ_FREE   = 3'd3;
    localparam logic [2:0] REQ_NEXT   = 3'd4;
    localparam logic [2:0] REQ_TAIL   = 3'd5;
    localparam logic [2:0] REQ_USAGE  = 3'd6;
    localparam logic [2:0] REQ_WRITE  = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Request word
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  cluster;
        logic [15:0] entry_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_cluster;
        logic [8:0]  used_count;
        logic [8:0]  free_count;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic req_load;
        logic sweep_start;
        logic sweep_step;
        logic scan_start;
        logic scan_step;
        logic rd_c;
        logic wr_c;
        logic set_oor;
        logic take_rd;
        logic free_step;
        logic tail_step;
        logic link_wr;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] req_type;
        logic       c_ok;
        logic       c_stop;
        logic       rd_is_end;
        logic       sweep_last;
        logic       scan_found;
        logic       scan_end;
        logic       walk_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/cce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cce_ctrl.sv]
// Cluster chain table engine: controller state machine.
// Sequences the datapath through commands; depends on cce_pkg.
`default_nettype none

module cce_ctrl
    import cce_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_RSTART   = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_IDLE     = 4'd2;
    localparam logic [3:0] S_DISP     = 4'd3;
    localparam logic [3:0] S_FMT      = 4'd4;
    localparam logic [3:0] S_SCAN     = 4'd5;
    localparam logic [3:0] S_EXT_CHK  = 4'd6;
    localparam logic [3:0] S_EXT_LINK = 4'd7;
    localparam logic [3:0] S_FREE     = 4'd8;
    localparam logic [3:0] S_TAIL     = 4'd9;
    localparam logic [3:0] S_NEXT     = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_RSTART: begin
                cmd.sweep_start = 1'b1;
                n_state         = S_INIT;
            end
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.req_load = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req_type)
                    REQ_FORMAT: begin
                        cmd.sweep_start = 1'b1;
                        n_state         = S_FMT;
                    end
                    REQ_ALLOC, REQ_USAGE: begin
                        cmd.scan_start = 1'b1;
                        n_state        = S_SCAN;
                    end
                    REQ_EXTEND: begin
                        if (!i_sts.c_ok) begin
                            cmd.set_oor = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.rd_c = 1'b1;
                            n_state  = S_EXT_CHK;
                        end
                    end
                    REQ_FREE: begin
                        if (!i_sts.c_ok) begin
                            cmd.set_oor = 1'b1;
                            n_state     = S_DONE;
                        end else if (i_sts.c_stop) begin
                            n_state = S_DONE;
                        end else begin
                            cmd.rd_c = 1'b1;
                            n_state  = S_FREE;
                        end
                    end
                    REQ_NEXT: begin
                        if (!i_sts.c_ok) begin
                            cmd.set_oor = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.rd_c = 1'b1;
                            n_state  = S_NEXT;
                        end
                    end
                    REQ_TAIL: begin
                        if (!i_sts.c_ok) begin
                            cmd.set_oor = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.rd_c = 1'b1;
                            n_state  = S_TAIL;
                        end
                    end
                    REQ_WRITE: begin
                        if (!i_sts.c_ok) begin
                            cmd.set_oor = 1'b1;
                        end else begin
                            cmd.wr_c = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FMT: begin
                cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_sts.scan_found) begin
                    n_state = (i_sts.req_type == REQ_EXTEND) ? S_EXT_LINK : S_DONE;
                end else if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_EXT_CHK: begin
                if (i_sts.rd_is_end) begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    cmd.take_rd = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_EXT_LINK: begin
                cmd.link_wr = 1'b1;
                n_state     = S_DONE;
            end
            S_FREE: begin
                cmd.free_step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_TAIL: begin
                cmd.tail_step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_NEXT: begin
                cmd.take_rd = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RSTART;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/cce_dp.sv]
// Cluster chain table engine: datapath with the table RAM, pointers,
// counters and result registers. Depends on cce_pkg and cce_ram.
`default_nettype none

module cce_dp
    import cce_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_word   i_in_data,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output t_out_word       o_out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [15:0]      N16      = 16'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);

    // Control registers
    logic [7:0]       r_ds;
    logic             r_rd_vld;
    logic             r_byp_vld;

    // Working registers
    t_in_word         r_req;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_fmt_ds;
    logic [IDX_W-1:0] r_cur;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_status;
    logic [15:0]      r_rc;
    logic [IDX_W-1:0] r_rd_addr;
    logic [15:0]      r_byp_data;
    t_out_word        r_out;

    // RAM ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0]      ram_q;

    logic [15:0]      in_c16;
    logic [15:0]      c16;
    logic             c_ok;
    logic [IDX_W-1:0] c_idx;
    logic [15:0]      ds16;
    logic [15:0]      eff16;
    logic [CNT_W-1:0] eff_ds;
    logic [CNT_W-1:0] alloc_start;
    logic             alloc_mode;
    logic [15:0]      rd_word;
    logic             rd_zero;
    logic             rd_end;
    logic             rd_in;
    logic [IDX_W-1:0] rd_idx;
    logic             ptr_end;
    logic             scan_found;
    logic             scan_end;
    logic             free_go;
    logic             tail_link;
    logic [CNT_W-1:0] used_w;
    logic [CNT_W-1:0] free_w;

    cce_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Request decode and effective data start
    assign in_c16      = 16'(i_in_data.cluster);
    assign c16         = 16'(r_req.cluster);
    assign c_ok        = (c16 < N16);
    assign c_idx       = c16[IDX_W-1:0];
    assign ds16        = 16'(r_ds);
    assign eff16       = (ds16 < N16) ? ds16 : N16;
    assign eff_ds      = eff16[CNT_W-1:0];
    assign alloc_start = (eff_ds == '0) ? CNT_W'(1) : eff_ds;
    assign alloc_mode  = (r_req.req_type == REQ_ALLOC) || (r_req.req_type == REQ_EXTEND);

    // Read data, with the word written in the same cycle as its read forwarded
    assign rd_word = r_byp_vld ? r_byp_data : ram_q;
    assign rd_zero = (rd_word == 16'd0);
    assign rd_end  = (rd_word == END_MARK);
    assign rd_in   = (rd_word < N16);
    assign rd_idx  = rd_word[IDX_W-1:0];

    // Scan and walk conditions
    assign ptr_end    = (r_ptr == N_CNT);
    assign scan_found = alloc_mode && r_rd_vld && rd_zero;
    assign scan_end   = !r_rd_vld && ptr_end;
    assign free_go    = !rd_zero && !rd_end && rd_in;
    assign tail_link  = !rd_zero && !rd_end && rd_in && (r_cnt != LAST_CNT);

    // RAM port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = c_idx;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = c_idx;
        if (i_cmd.sweep_step) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr[IDX_W-1:0];
            wr_data = (r_ptr < r_fmt_ds) ? END_MARK : 16'd0;
        end
        if (i_cmd.scan_step) begin
            if (!ptr_end && !scan_found) begin
                rd_en   = 1'b1;
                rd_addr = r_ptr[IDX_W-1:0];
            end
            if (scan_found) begin
                wr_en   = 1'b1;
                wr_addr = r_rd_addr;
                wr_data = END_MARK;
            end
        end
        if (i_cmd.rd_c) begin
            rd_en   = 1'b1;
            rd_addr = c_idx;
        end
        if (i_cmd.wr_c) begin
            wr_en   = 1'b1;
            wr_addr = c_idx;
            wr_data = r_req.entry_value;
        end
        if (i_cmd.free_step) begin
            wr_en   = 1'b1;
            wr_addr = r_cur;
            wr_data = 16'd0;
            if (free_go) begin
                rd_en   = 1'b1;
                rd_addr = rd_idx;
            end
        end
        if (i_cmd.tail_step && tail_link) begin
            rd_en   = 1'b1;
            rd_addr = rd_idx;
        end
        if (i_cmd.link_wr) begin
            wr_en   = 1'b1;
            wr_addr = c_idx;
            wr_data = r_rc;
        end
    end

    // Counts for the result word
    always_comb begin
        used_w = '0;
        free_w = '0;
        case (r_req.req_type)
            REQ_USAGE: begin
                used_w = r_fmt_ds + r_cnt;
                free_w = N_CNT - used_w;
            end
            REQ_FREE: begin
                used_w = r_cnt;
            end
            default: begin
                used_w = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds      <= DS_RESET;
            r_rd_vld  <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ds <= i_cfg_data;
            end
            r_rd_vld  <= rd_en;
            r_byp_vld <= rd_en && wr_en && (rd_addr == wr_addr);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= rd_addr;
        r_byp_data <= wr_data;
        if (i_cmd.req_load) begin
            r_req    <= i_in_data;
            r_cur    <= in_c16[IDX_W-1:0];
            r_cnt    <= '0;
            r_status <= ST_OK;
            r_rc     <= 16'd0;
        end
        if (i_cmd.sweep_start) begin
            r_ptr    <= '0;
            r_fmt_ds <= eff_ds;
        end
        if (i_cmd.sweep_step) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
        if (i_cmd.scan_start) begin
            r_ptr    <= alloc_mode ? alloc_start : eff_ds;
            r_fmt_ds <= eff_ds;
        end
        if (i_cmd.scan_step) begin
            if (!ptr_end && !scan_found) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (!alloc_mode && r_rd_vld && !rd_zero) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (scan_found) begin
                r_rc <= 16'(r_rd_addr);
            end
            if (alloc_mode && scan_end) begin
                r_status <= ST_NOFREE;
            end
        end
        if (i_cmd.set_oor) begin
            r_status <= ST_RANGE;
        end
        if (i_cmd.wr_c) begin
            r_rc <= r_req.entry_value;
        end
        if (i_cmd.take_rd) begin
            r_rc <= rd_word;
        end
        // Free one entry and advance along the chain
        if (i_cmd.free_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_cur <= rd_idx;
        end
        // Follow one link toward the tail
        if (i_cmd.tail_step) begin
            if (rd_zero || rd_end) begin
                r_rc <= 16'(r_cur);
            end else if (!rd_in) begin
                r_status <= ST_RANGE;
            end else begin
                r_cur <= rd_idx;
                if (r_cnt == LAST_CNT) begin
                    r_rc <= rd_word;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out.status         <= r_status;
            r_out.result_cluster <= r_rc;
            r_out.used_count     <= 9'(used_w);
            r_out.free_count     <= 9'(free_w);
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.req_type   = r_req.req_type;
        o_sts.c_ok       = c_ok;
        o_sts.c_stop     = (c16 == 16'd0) || (c16 == END_MARK);
        o_sts.rd_is_end  = rd_end;
        o_sts.sweep_last = (r_ptr == LAST_CNT);
        o_sts.scan_found = scan_found;
        o_sts.scan_end   = scan_end;
        o_sts.walk_done  = (r_req.req_type == REQ_TAIL) ? !tail_link : !free_go;
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[hw/rtl/cluster_chain_table_engine_core.sv]
// Cluster chain table engine top level: joins the controller and the datapath.
// Depends on cce_pkg, cce_ctrl, cce_dp (and cce_ram below it).
//
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_data) takes one command word;
//   result channel (o_out_valid / i_out_stall / o_out_data) returns one word per
//   command. A word moves at a clock edge with valid high and stall low.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the data
//   start; ready is always high. Write it only while no command is in flight.
//   One command is in work at a time; the next is taken once the result sits in
//   the output register, even if the receiver still stalls it. Free chain and
//   tail follow one link at a time through the table RAM read port; allocate
//   scans from the data start for a free entry, usage counts entries from the
//   data start, extend of an end entry allocates a new entry and links it, and
//   format rewrites the table with the data start. After reset the table RAM
//   gets a format pass with data start 8; o_in_stall stays high meanwhile,
//   configuration writes are taken.
//   A stalled result holds; the finished command after it waits in the engine.
`default_nettype none

module cluster_chain_table_engine_core
    import cce_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    cce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    cce_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_data  (o_out_data)
    );

    // Configuration word is always taken
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cluster_chain_table_engine_core: a scoreboard class keeps
// its own copy of the cluster table and predicts every result word. Depends on cce_pkg.

module testbench;
    import cce_pkg::*;

    localparam int TABLE_N   = 256;
    localparam int HOLD_LEN  = 600;
    localparam int DRAIN_LEN = 300;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 130;

    // Scoreboard: private cluster table, data start and queue of due result words
    class cluster_table_board;
        logic [15:0] entries [TABLE_N];
        logic [7:0]  start_reg;
        t_out_word   due_replies [$];
        t_out_word   last_reply;
        int          errors;

        function new();
            start_reg = DS_RESET;
            errors    = 0;
            format_all();
        endfunction

        // Mark reserved entries as chain ends and free the rest
        function void format_all();
            for (int i = 0; i < TABLE_N; i++) begin
                entries[i] = (i < start_reg) ? END_MARK : 16'h0000;
            end
        endfunction

        // Take the first free entry at or above the data start, never cluster 0
        function bit grab_free(output logic [15:0] idx);
            int i;
            i   = (start_reg == 8'd0) ? 1 : start_reg;
            idx = '0;
            while (i < TABLE_N) begin
                if (entries[i] == 16'h0000) begin
                    entries[i] = END_MARK;
                    idx        = 16'(i);
                    return 1'b1;
                end
                i++;
            end
            return 1'b0;
        endfunction

        // Apply one accepted request word and queue the result word it must give.
        // The 8-bit cluster field always indexes inside the table.
        function void note_request(t_in_word w);
            t_out_word   r;
            logic [15:0] n;
            int          cur;
            int          count;
            r = '0;
            case (w.req_type)
                REQ_FORMAT: begin
                    format_all();
                end
                REQ_ALLOC: begin
                    if (grab_free(n)) begin
                        r.result_cluster = n;
                    end else begin
                        r.status = ST_NOFREE;
                    end
                end
                REQ_EXTEND: begin
                    if (entries[w.cluster] == END_MARK) begin
                        if (grab_free(n)) begin
                            entries[w.cluster] = n;
                            r.result_cluster   = n;
                        end else begin
                            r.status = ST_NOFREE;
                        end
                    end else begin
                        r.result_cluster = entries[w.cluster];
                    end
                end
                REQ_FREE: begin
                    // walk and clear until a free mark, an end mark or a link off the table
                    cur   = w.cluster;
                    count = 0;
                    while (cur != 0 && cur != END_MARK && cur < TABLE_N) begin
                        n            = entries[cur];
                        entries[cur] = 16'h0000;
                        count++;
                        cur = n;
                    end
                    r.used_count = 9'(count);
                end
                REQ_NEXT: begin
                    r.result_cluster = entries[w.cluster];
                end
                REQ_TAIL: begin
                    // bounded walk so that a looped chain still ends
                    cur = w.cluster;
                    for (int steps = 0; steps < TABLE_N; steps++) begin
                        n = entries[cur];
                        if (n == 16'h0000 || n == END_MARK) begin
                            break;
                        end
                        if (n >= TABLE_N) begin
                            r.status = ST_RANGE;
                            break;
                        end
                        cur = n;
                    end
                    if (r.status == ST_OK) begin
                        r.result_cluster = 16'(cur);
                    end
                end
                REQ_USAGE: begin
                    count = start_reg;
                    for (int i = start_reg; i < TABLE_N; i++) begin
                        if (entries[i] != 16'h0000) begin
                            count++;
                        end
                    end
                    r.used_count = 9'(count);
                    r.free_count = 9'(TABLE_N - count);
                end
                REQ_WRITE: begin
                    entries[w.cluster] = w.entry_value;
                    r.result_cluster   = w.entry_value;
                end
            endcase
            last_reply = r;
            due_replies.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest due word
        function void check_reply(t_out_word got);
            t_out_word want;
            if (due_replies.size() == 0) begin
                $error("result word %h arrived with nothing due", got);
                errors++;
                return;
            end
            want = due_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.result_cluster !== want.result_cluster) begin
                $error("result_cluster: expected %0d, got %0d",
                       want.result_cluster, got.result_cluster);
                errors++;
            end
            if (got.used_count !== want.used_count) begin
                $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_word   in_word   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;
    bit         quiet     = 1'b0;
    bit         hold_kick = 1'b0;
    logic [7:0] chain_heads [$];

    cluster_table_board board = new();

    cluster_chain_table_engine_core #(
        .TABLE_ENTRIES(TABLE_N)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Check every result word taken at a rising edge
    always @(posedge clk) begin
        if (out_valid === 1'b1 && out_stall == 1'b0) begin
            board.check_reply(out_word);
        end
    end

    // Stall the result side at random, or hold it off for a long stretch on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_kick) begin
                hold_kick = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 32);
            end
        end
    end

    // Offer one request word after an optional gap; returns at a falling edge
    task automatic send_req(input logic [2:0] req, input logic [7:0] c,
                            input logic [15:0] v);
        t_in_word w;
        w.req_type    = req;
        w.cluster     = c;
        w.entry_value = v;
        while (!quiet && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(posedge clk);
        end while (in_stall !== 1'b0);
        board.note_request(w);
        @(negedge clk);
    endtask

    // Drop valid and wait until every due result word has come back
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (board.due_replies.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Write the data start register; called at a falling edge while idle
    task automatic write_start(input logic [7:0] ds);
        cfg_valid <= 1'b1;
        cfg_data  <= ds;
        do begin
            @(posedge clk);
        end while (cfg_ready !== 1'b1);
        board.start_reg = ds;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a known chain head, sometimes any cluster
    function automatic logic [7:0] pick_cluster();
        if (chain_heads.size() != 0 && $urandom_range(0, 99) < 60) begin
            return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        end
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        logic [7:0]  start_plan [PHASES];
        logic [7:0]  head;
        logic [7:0]  last;
        logic [7:0]  c;
        logic [15:0] v;
        int          sent;
        int          pick;
        int          links;
        int          slot;

        start_plan = '{8'd1, 8'd255, 8'd0, DS_RESET, 8'($urandom_range(2, 254)),
                       8'($urandom_range(2, 254)), 8'd16, 8'd128};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_start(DS_RESET);

        // Directed words on the freshly formatted table
        send_req(REQ_USAGE, 8'h00, 16'h0000);
        send_req(REQ_NEXT, 8'h00, 16'hFFFF);
        send_req(REQ_NEXT, 8'hFF, 16'h0000);
        send_req(REQ_ALLOC, 8'hFF, 16'hFFFF);
        send_req(REQ_EXTEND, 8'd8, 16'h0000);
        send_req(REQ_EXTEND, 8'd8, 16'h0000);
        send_req(REQ_EXTEND, 8'd100, 16'h0000);
        send_req(REQ_TAIL, 8'd8, 16'h0000);
        send_req(REQ_WRITE, 8'd9, 16'd200);
        send_req(REQ_TAIL, 8'd8, 16'h0000);
        // link that leaves the table
        send_req(REQ_WRITE, 8'd9, 16'h1234);
        send_req(REQ_TAIL, 8'd8, 16'h0000);
        send_req(REQ_EXTEND, 8'd9, 16'h0000);
        send_req(REQ_FREE, 8'd8, 16'h0000);
        // chain that loops on itself
        send_req(REQ_WRITE, 8'd20, 16'd20);
        send_req(REQ_TAIL, 8'd20, 16'h0000);
        send_req(REQ_FREE, 8'd20, 16'h0000);
        send_req(REQ_FREE, 8'd0, 16'hFFFF);
        send_req(REQ_WRITE, 8'hFF, 16'hFFFF);
        send_req(REQ_TAIL, 8'hFF, 16'h0000);
        send_req(REQ_WRITE, 8'hFF, 16'h0000);
        send_req(REQ_FORMAT, 8'hFF, 16'hFFFF);
        send_req(REQ_USAGE, 8'hFF, 16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            drain_replies();
            write_start(start_plan[p]);
            quiet = (p == 3);
            if (p == 5) begin
                hold_kick = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                send_req(REQ_FORMAT, 8'($urandom), 16'($urandom));
                chain_heads.delete();
            end
            sent = 0;
            while (sent < PHASE_LEN) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // build a chain: allocate, extend from its end, then walk it
                    send_req(REQ_ALLOC, 8'($urandom), 16'($urandom));
                    sent++;
                    if (board.last_reply.status == ST_OK) begin
                        head  = board.last_reply.result_cluster[7:0];
                        last  = head;
                        links = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                            : $urandom_range(0, 5);
                        repeat (links) begin
                            send_req(REQ_EXTEND, last, 16'($urandom));
                            sent++;
                            if (board.last_reply.status != ST_OK) begin
                                break;
                            end
                            last = board.last_reply.result_cluster[7:0];
                        end
                        if (chain_heads.size() > 40) begin
                            void'(chain_heads.pop_front());
                        end
                        chain_heads.push_back(head);
                        send_req(REQ_TAIL, head, 16'($urandom));
                        sent++;
                    end
                end else if (pick < 48) begin
                    // release a chain, mostly one that was built
                    if (chain_heads.size() != 0 && $urandom_range(0, 3) != 0) begin
                        slot = $urandom_range(0, chain_heads.size() - 1);
                        c    = chain_heads[slot];
                        chain_heads.delete(slot);
                    end else begin
                        c = 8'($urandom);
                    end
                    send_req(REQ_FREE, c, 16'($urandom));
                    sent++;
                end else if (pick < 58) begin
                    send_req(REQ_TAIL, pick_cluster(), 16'($urandom));
                    sent++;
                end else if (pick < 65) begin
                    send_req(REQ_USAGE, 8'($urandom), 16'($urandom));
                    sent++;
                end else if (pick < 78) begin
                    // corrupt or relink an entry
                    case ($urandom_range(0, 4))
                        0: v = 16'h0000;
                        1: v = END_MARK;
                        2: v = 16'($urandom_range(0, TABLE_N - 1));
                        3: v = 16'($urandom_range(TABLE_N, 16'hFFFE));
                        default: v = 16'($urandom);
                    endcase
                    send_req(REQ_WRITE, pick_cluster(), v);
                    sent++;
                end else if (pick < 87) begin
                    send_req(REQ_NEXT, pick_cluster(), 16'($urandom));
                    sent++;
                end else if (pick < 89) begin
                    send_req(REQ_FORMAT, 8'($urandom), 16'($urandom));
                    chain_heads.delete();
                    sent++;
                end else begin
                    // noise: any command with any content
                    send_req(3'($urandom), 8'($urandom), 16'($urandom));
                    sent++;
                end
            end
            quiet = 1'b0;
        end

        drain_replies();
        repeat (DRAIN_LEN) @(posedge clk);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // End a hung run
    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cce_pkg.sv
hw/rtl/cce_ram.sv
hw/rtl/cce_ctrl.sv
hw/rtl/cce_dp.sv
hw/rtl/cluster_chain_table_engine_core.sv
tb/testbench.sv
